@@ rtl/core/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared macros for the concurrent checks of the key counter.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on the rising clock edge while reset is released.
`define CHKC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a value is zero whenever a condition holds.
`define CHKC_ASSERT_ZERO(label, clk, rst_n, cond, val, msg) \
    `CHKC_ASSERT(label, clk, rst_n, (cond) |-> ((val) == '0), msg)

`endif

@@ rtl/core/chkc_pkg.sv @@
// ============================================================================
// Key counter package
// Types, codes and defaults shared by the chained hash key counter.
// ============================================================================
package chkc_pkg;

    localparam int DEF_NUM_BUCKETS  = 251;
    localparam int DEF_POOL_ENTRIES = 256;
    localparam int DEF_KEY_WORDS    = 8;

    localparam logic [1:0] CMD_INC  = 2'd0;
    localparam logic [1:0] CMD_DEC  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_HEAD_WT,
        S_CHECK,
        S_KEY,
        S_ACT,
        S_ALLOC,
        S_LINK,
        S_KEYW,
        S_FREE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic init_wr;
        logic load;
        logic hash;
        logic head_rd;
        logic head_take;
        logic probe;
        logic key_cmp;
        logic act;
        logic alloc_rd;
        logic alloc_wr;
        logic key_wr;
        logic free_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic chain_end;
        logic key_eq;
        logic word_last;
        logic alloc_go;
        logic free_go;
    } t_dp_stat;

endpackage

@@ rtl/core/chkc_ram.sv @@
// ============================================================================
// Generic RAM
// Single write port, single read port with registered read data.
// ============================================================================
module chkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/chkc_ctrl.sv @@
// ============================================================================
// Key counter controller
// Sequences clearing, hashing, chain walk, update and response.
// ============================================================================
module chkc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  chkc_pkg::t_dp_stat i_stat,
    output chkc_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    chkc_pkg::t_state r_state;
    chkc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chkc_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chkc_pkg::S_INIT: begin
                if (i_stat.init_last) n_state = chkc_pkg::S_IDLE;
            end
            chkc_pkg::S_IDLE: begin
                if (i_start) n_state = chkc_pkg::S_HASH;
            end
            chkc_pkg::S_HASH:    n_state = chkc_pkg::S_HEAD;
            chkc_pkg::S_HEAD:    n_state = chkc_pkg::S_HEAD_WT;
            chkc_pkg::S_HEAD_WT: n_state = chkc_pkg::S_CHECK;
            chkc_pkg::S_CHECK: begin
                n_state = i_stat.chain_end ? chkc_pkg::S_ACT : chkc_pkg::S_KEY;
            end
            chkc_pkg::S_KEY: begin
                if (!i_stat.key_eq) begin
                    n_state = chkc_pkg::S_CHECK;
                end else if (i_stat.word_last) begin
                    n_state = chkc_pkg::S_ACT;
                end
            end
            chkc_pkg::S_ACT: begin
                if (i_stat.alloc_go) begin
                    n_state = chkc_pkg::S_ALLOC;
                end else if (i_stat.free_go) begin
                    n_state = chkc_pkg::S_FREE;
                end else begin
                    n_state = chkc_pkg::S_RESP;
                end
            end
            chkc_pkg::S_ALLOC: n_state = chkc_pkg::S_LINK;
            chkc_pkg::S_LINK:  n_state = chkc_pkg::S_KEYW;
            chkc_pkg::S_KEYW: begin
                if (i_stat.word_last) n_state = chkc_pkg::S_RESP;
            end
            chkc_pkg::S_FREE: n_state = chkc_pkg::S_RESP;
            chkc_pkg::S_RESP: n_state = chkc_pkg::S_IDLE;
            default:          n_state = chkc_pkg::S_INIT;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            chkc_pkg::S_INIT:    o_cmd.init_wr = 1'b1;
            chkc_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            chkc_pkg::S_HASH:    o_cmd.hash = 1'b1;
            chkc_pkg::S_HEAD:    o_cmd.head_rd = 1'b1;
            chkc_pkg::S_HEAD_WT: o_cmd.head_take = 1'b1;
            chkc_pkg::S_CHECK:   o_cmd.probe = 1'b1;
            chkc_pkg::S_KEY:     o_cmd.key_cmp = 1'b1;
            chkc_pkg::S_ACT:     o_cmd.act = 1'b1;
            chkc_pkg::S_ALLOC:   o_cmd.alloc_rd = 1'b1;
            chkc_pkg::S_LINK:    o_cmd.alloc_wr = 1'b1;
            chkc_pkg::S_KEYW:    o_cmd.key_wr = 1'b1;
            chkc_pkg::S_FREE:    o_cmd.free_wr = 1'b1;
            chkc_pkg::S_RESP:    o_done = 1'b1;
            default:             o_busy = 1'b1;
        endcase
    end

endmodule

@@ rtl/core/chkc_dp.sv @@
// ============================================================================
// Key counter datapath
// Bucket heads, entry pool memories, chain walk registers and totals.
// ============================================================================
module chkc_dp #(
    parameter int NUM_BUCKETS  = chkc_pkg::DEF_NUM_BUCKETS,
    parameter int POOL_ENTRIES = chkc_pkg::DEF_POOL_ENTRIES,
    parameter int KEY_WORDS    = chkc_pkg::DEF_KEY_WORDS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  chkc_pkg::t_dp_cmd  i_cmd,
    output chkc_pkg::t_dp_stat o_stat,
    input  logic [1:0]         i_cmd_code,
    input  logic [63:0]        i_key [8],
    output logic [31:0]        o_key_count,
    output logic [1:0]         o_status,
    output logic [8:0]         o_distinct_keys,
    output logic [31:0]        o_total_hits
);

    localparam int IW   = $clog2(POOL_ENTRIES + 1);
    localparam int AW   = $clog2(POOL_ENTRIES);
    localparam int BW   = $clog2(NUM_BUCKETS);
    localparam int KWB  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int KAW  = AW + KWB;
    localparam int MAXN = (NUM_BUCKETS > POOL_ENTRIES) ? NUM_BUCKETS : POOL_ENTRIES;
    localparam int CW   = $clog2(MAXN);

    localparam logic [IW-1:0]  NIL      = IW'(POOL_ENTRIES);
    localparam logic [BW:0]    NB_W     = (BW + 1)'(NUM_BUCKETS);
    localparam logic [CW:0]    NB_C     = (CW + 1)'(NUM_BUCKETS);
    localparam logic [CW:0]    PE_C     = (CW + 1)'(POOL_ENTRIES);
    localparam logic [CW-1:0]  INIT_END = CW'(MAXN - 1);
    localparam logic [KWB-1:0] WORD_END = KWB'(KEY_WORDS - 1);

    logic [1:0]     r_cmd;
    logic [63:0]    r_key [KEY_WORDS];
    logic [BW-1:0]  r_bucket;
    logic [IW-1:0]  r_head;
    logic [IW-1:0]  r_cur;
    logic [IW-1:0]  r_prev;
    logic [IW-1:0]  r_steps;
    logic [KWB-1:0] r_word;
    logic           r_found;
    logic [IW-1:0]  r_free;
    logic [IW-1:0]  r_distinct;
    logic [31:0]    r_hits;
    logic [CW-1:0]  r_init;
    logic [31:0]    r_res_count;
    logic [1:0]     r_res_status;

    logic [63:0]   fold_x;
    logic [BW-1:0] fold_f;
    logic [BW:0]   fold_w;

    logic [IW-1:0]  head_rdata;
    logic [IW-1:0]  link_rdata;
    logic [31:0]    cnt_rdata;
    logic [63:0]    key_rdata;

    logic           head_we;
    logic [BW-1:0]  head_waddr;
    logic [IW-1:0]  head_wdata;
    logic           link_we;
    logic [AW-1:0]  link_waddr;
    logic [IW-1:0]  link_wdata;
    logic           link_re;
    logic [AW-1:0]  link_raddr;
    logic           cnt_we;
    logic [AW-1:0]  cnt_waddr;
    logic [31:0]    cnt_wdata;
    logic           key_we;
    logic           key_re;
    logic [KAW-1:0] key_raddr;

    logic           chain_end;
    logic           key_eq;
    logic           word_last;
    logic           init_in_nb;
    logic           init_in_pe;

    logic [31:0]    act_count;
    logic [1:0]     act_status;
    logic           act_cnt_we;
    logic [31:0]    act_cnt_wdata;
    logic           act_hit_inc;
    logic           act_hit_dec;
    logic           alloc_go;
    logic           free_go;

    always_comb begin
        fold_x = '0;
        for (int w = 0; w < KEY_WORDS; w++) begin
            fold_x = fold_x ^ r_key[w];
        end
        fold_f = '0;
        for (int i = 0; i < 64; i++) begin
            fold_f[i % BW] = fold_f[i % BW] ^ fold_x[i];
        end
        fold_w = {1'b0, fold_f};
        if (fold_w >= NB_W) begin
            fold_w = fold_w - NB_W;
        end
    end

    assign chain_end  = (r_cur >= NIL) || (r_steps >= NIL);
    assign key_eq     = (key_rdata == r_key[r_word]);
    assign word_last  = (r_word == WORD_END);
    assign init_in_nb = ({1'b0, r_init} < NB_C);
    assign init_in_pe = ({1'b0, r_init} < PE_C);

    always_comb begin
        act_count     = '0;
        act_status    = chkc_pkg::ST_OK;
        act_cnt_we    = 1'b0;
        act_cnt_wdata = '0;
        act_hit_inc   = 1'b0;
        act_hit_dec   = 1'b0;
        alloc_go      = 1'b0;
        free_go       = 1'b0;
        case (r_cmd)
            chkc_pkg::CMD_INC: begin
                if (r_found) begin
                    if ((cnt_rdata == '1) || (r_hits == '1)) begin
                        act_status = chkc_pkg::ST_OVF;
                        act_count  = cnt_rdata;
                    end else begin
                        act_cnt_we    = 1'b1;
                        act_cnt_wdata = cnt_rdata + 32'd1;
                        act_count     = cnt_rdata + 32'd1;
                        act_hit_inc   = 1'b1;
                    end
                end else if (r_hits == '1) begin
                    act_status = chkc_pkg::ST_OVF;
                end else if (r_free >= NIL) begin
                    act_status = chkc_pkg::ST_FULL;
                end else begin
                    alloc_go    = 1'b1;
                    act_count   = 32'd1;
                    act_hit_inc = 1'b1;
                end
            end
            chkc_pkg::CMD_DEC: begin
                if (!r_found || (cnt_rdata == '0)) begin
                    act_status = chkc_pkg::ST_ABSENT;
                end else begin
                    act_cnt_we    = 1'b1;
                    act_cnt_wdata = cnt_rdata - 32'd1;
                    act_count     = cnt_rdata - 32'd1;
                    act_hit_dec   = 1'b1;
                    free_go       = (cnt_rdata == 32'd1);
                end
            end
            default: begin
                act_count = r_found ? cnt_rdata : '0;
            end
        endcase
    end

    always_comb begin
        head_we    = 1'b0;
        head_waddr = r_bucket;
        head_wdata = NIL;
        link_we    = 1'b0;
        link_waddr = r_cur[AW-1:0];
        link_wdata = r_free;
        if (i_cmd.init_wr) begin
            head_we    = init_in_nb;
            head_waddr = r_init[BW-1:0];
            link_we    = init_in_pe;
            link_waddr = r_init[AW-1:0];
            link_wdata = IW'(r_init) + IW'(1);
        end else if (i_cmd.act && free_go) begin
            if (r_prev == NIL) begin
                head_we    = 1'b1;
                head_wdata = link_rdata;
            end else begin
                link_we    = 1'b1;
                link_waddr = r_prev[AW-1:0];
                link_wdata = link_rdata;
            end
        end else if (i_cmd.alloc_wr) begin
            head_we    = 1'b1;
            head_wdata = r_free;
            link_we    = 1'b1;
            link_waddr = r_free[AW-1:0];
            link_wdata = r_head;
        end else if (i_cmd.free_wr) begin
            link_we = 1'b1;
        end
    end

    assign link_re    = (i_cmd.probe && !chain_end) || i_cmd.alloc_rd;
    assign link_raddr = i_cmd.alloc_rd ? r_free[AW-1:0] : r_cur[AW-1:0];

    assign cnt_we    = (i_cmd.act && act_cnt_we) || i_cmd.alloc_wr;
    assign cnt_waddr = i_cmd.alloc_wr ? r_free[AW-1:0] : r_cur[AW-1:0];
    assign cnt_wdata = i_cmd.alloc_wr ? 32'd1 : act_cnt_wdata;

    assign key_we    = i_cmd.key_wr;
    assign key_re    = (i_cmd.probe && !chain_end) || (i_cmd.key_cmp && key_eq && !word_last);
    assign key_raddr = i_cmd.probe ? {r_cur[AW-1:0], KWB'(0)}
                                   : {r_cur[AW-1:0], r_word + KWB'(1)};

    chkc_ram #(.WIDTH(IW), .DEPTH(NUM_BUCKETS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (i_cmd.head_rd),
        .i_raddr (r_bucket),
        .o_rdata (head_rdata)
    );

    chkc_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    chkc_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (i_cmd.probe && !chain_end),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (cnt_rdata)
    );

    chkc_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES << KWB)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr ({r_cur[AW-1:0], r_word}),
        .i_wdata (r_key[r_word]),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free     <= '0;
            r_distinct <= '0;
            r_hits     <= '0;
            r_init     <= '0;
        end else begin
            if (i_cmd.init_wr) begin
                r_init <= r_init + CW'(1);
            end
            if (i_cmd.act) begin
                if (act_hit_inc) r_hits <= r_hits + 32'd1;
                if (act_hit_dec) r_hits <= r_hits - 32'd1;
                if (alloc_go)    r_distinct <= r_distinct + IW'(1);
                if (free_go)     r_distinct <= r_distinct - IW'(1);
            end
            if (i_cmd.alloc_wr) begin
                r_free <= link_rdata;
            end
            if (i_cmd.free_wr) begin
                r_free <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_cmd_code;
            for (int w = 0; w < KEY_WORDS; w++) begin
                r_key[w] <= i_key[w];
            end
        end
        if (i_cmd.hash) begin
            r_bucket <= fold_w[BW-1:0];
        end
        if (i_cmd.head_take) begin
            r_head  <= head_rdata;
            r_cur   <= head_rdata;
            r_prev  <= NIL;
            r_steps <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.probe) begin
            r_word <= '0;
        end
        if (i_cmd.key_cmp) begin
            if (!key_eq) begin
                r_prev  <= r_cur;
                r_cur   <= link_rdata;
                r_steps <= r_steps + IW'(1);
            end else if (word_last) begin
                r_found <= 1'b1;
            end else begin
                r_word <= r_word + KWB'(1);
            end
        end
        if (i_cmd.act) begin
            r_res_count  <= act_count;
            r_res_status <= act_status;
        end
        if (i_cmd.alloc_wr) begin
            r_cur  <= r_free;
            r_word <= '0;
        end
        if (i_cmd.key_wr) begin
            r_word <= r_word + KWB'(1);
        end
    end

    assign o_stat.init_last = (r_init == INIT_END);
    assign o_stat.chain_end = chain_end;
    assign o_stat.key_eq    = key_eq;
    assign o_stat.word_last = word_last;
    assign o_stat.alloc_go  = alloc_go;
    assign o_stat.free_go   = free_go;

    assign o_key_count     = r_res_count;
    assign o_status        = r_res_status;
    assign o_distinct_keys = 9'(r_distinct);
    assign o_total_hits    = r_hits;

endmodule

@@ rtl/core/chained_hash_key_counter_top.sv @@
// ============================================================================
// Chained hash key counter
// Counting hash table with bucket chains over a fixed entry pool.
// ============================================================================
// Channel   Direction  Handshake       Beat content
// command   in         start / busy    i_cmd, i_key_word_0 .. i_key_word_7
// result    out        o_done strobe   o_key_count, o_status, o_distinct_keys,
//                                      o_total_hits
//
// One command at a time. A command passes through hashing, the bucket head read,
// a word-by-word key compare on the key memory for each chain entry visited, and
// the count update, plus the allocation, link and key write for a new entry or the
// free-chain write for a freed entry, before its result beat.
// After reset, busy stays high while the bucket heads
// and the free chain are initialized.
// The result beat is shown for one cycle and cannot be stalled.
// ============================================================================
module chained_hash_key_counter_top #(
    parameter int NUM_BUCKETS  = chkc_pkg::DEF_NUM_BUCKETS,
    parameter int POOL_ENTRIES = chkc_pkg::DEF_POOL_ENTRIES,
    parameter int KEY_WORDS    = chkc_pkg::DEF_KEY_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_key_word_0,
    input  logic [63:0] i_key_word_1,
    input  logic [63:0] i_key_word_2,
    input  logic [63:0] i_key_word_3,
    input  logic [63:0] i_key_word_4,
    input  logic [63:0] i_key_word_5,
    input  logic [63:0] i_key_word_6,
    input  logic [63:0] i_key_word_7,
    output logic        o_done,
    output logic [31:0] o_key_count,
    output logic [1:0]  o_status,
    output logic [8:0]  o_distinct_keys,
    output logic [31:0] o_total_hits
);

    chkc_pkg::t_dp_cmd  dp_cmd;
    chkc_pkg::t_dp_stat dp_stat;
    logic [63:0]        key_in [8];

    assign key_in[0] = i_key_word_0;
    assign key_in[1] = i_key_word_1;
    assign key_in[2] = i_key_word_2;
    assign key_in[3] = i_key_word_3;
    assign key_in[4] = i_key_word_4;
    assign key_in[5] = i_key_word_5;
    assign key_in[6] = i_key_word_6;
    assign key_in[7] = i_key_word_7;

    chkc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    chkc_dp #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .KEY_WORDS    (KEY_WORDS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cmd_code      (i_cmd),
        .i_key           (key_in),
        .o_key_count     (o_key_count),
        .o_status        (o_status),
        .o_distinct_keys (o_distinct_keys),
        .o_total_hits    (o_total_hits)
    );

endmodule

@@ rtl/core/chkc_chk.sv @@
// ============================================================================
// Key counter checker
// Port-level checks of the command handshake and result beats.
// ============================================================================
`include "assert_macros.svh"

module chkc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_key_count,
    input logic [1:0]  o_status
);

    `CHKC_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted beat did not raise busy")
    `CHKC_ASSERT(a_done_busy, i_clk, i_rst_n, o_done |-> busy, "result beat while idle")
    `CHKC_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |=> (!busy && !o_done), "no return to idle after result beat")
    `CHKC_ASSERT_ZERO(a_absent_zero, i_clk, i_rst_n, o_done && (o_status == chkc_pkg::ST_ABSENT), o_key_count, "absent key with nonzero count")
    `CHKC_ASSERT_ZERO(a_full_zero, i_clk, i_rst_n, o_done && (o_status == chkc_pkg::ST_FULL), o_key_count, "pool full with nonzero count")

endmodule

bind chained_hash_key_counter_top chkc_chk u_chkc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_key_count (o_key_count),
    .o_status    (o_status)
);

@@ tb/sv/tb_top.sv @@
// ============================================================================
// Chained hash key counter testbench
// Sends increment, decrement, read and spare commands with 512-bit keys.
// A directed table with typed results runs first. Random traffic follows:
// pool filling, then mixed traffic mostly over a reused key set. Random
// results are compared with a software key-count table kept by the bench.
// ============================================================================
module tb_top;

    localparam int POOL_SIZE = chkc_pkg::DEF_POOL_ENTRIES;
    localparam int KEY_SET   = 300;
    localparam int FILL_BEATS = 320;
    localparam int MIX_BEATS  = 580;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef bit [511:0] t_key;

    typedef struct packed {
        logic [31:0] key_count;
        logic [1:0]  status;
        logic [8:0]  distinct_keys;
        logic [31:0] total_hits;
    } t_result;

    typedef struct {
        logic [1:0] cmd;
        int         key_id;
        t_result    res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = chkc_pkg::CMD_READ;
    logic [63:0] i_key_word_0 = '0, i_key_word_1 = '0, i_key_word_2 = '0, i_key_word_3 = '0;
    logic [63:0] i_key_word_4 = '0, i_key_word_5 = '0, i_key_word_6 = '0, i_key_word_7 = '0;
    logic        o_done;
    logic [31:0] o_key_count;
    logic [1:0]  o_status;
    logic [8:0]  o_distinct_keys;
    logic [31:0] o_total_hits;

    chained_hash_key_counter_top dut (.*);

    always #4 i_clk = ~i_clk;

    int unsigned key_counts[t_key];
    int unsigned stored_keys;
    logic [31:0] hit_sum;
    t_result     pending_results[$];
    t_key        key_set[KEY_SET];
    int          errors;
    int          idle_pct;
    int          full_seen, absent_seen, beats_sent;

    function automatic t_result count_key(logic [1:0] cmd, t_key key);
        t_result r;
        bit      present;
        present = key_counts.exists(key);
        r = '0;
        if (cmd == chkc_pkg::CMD_INC) begin
            if (present) begin
                if (key_counts[key] == 32'hFFFF_FFFF || hit_sum == 32'hFFFF_FFFF) begin
                    r.status = chkc_pkg::ST_OVF;
                end else begin
                    key_counts[key]++;
                    hit_sum++;
                end
                r.key_count = key_counts[key];
            end else if (hit_sum == 32'hFFFF_FFFF) begin
                r.status = chkc_pkg::ST_OVF;
            end else if (stored_keys >= POOL_SIZE) begin
                r.status = chkc_pkg::ST_FULL;
            end else begin
                key_counts[key] = 1;
                stored_keys++;
                hit_sum++;
                r.key_count = 1;
            end
        end else if (cmd == chkc_pkg::CMD_DEC) begin
            if (!present) begin
                r.status = chkc_pkg::ST_ABSENT;
            end else begin
                key_counts[key]--;
                hit_sum--;
                r.key_count = key_counts[key];
                if (key_counts[key] == 0) begin
                    key_counts.delete(key);
                    stored_keys--;
                end
            end
        end else if (present) begin
            r.key_count = key_counts[key];
        end
        r.distinct_keys = stored_keys[8:0];
        r.total_hits    = hit_sum;
        return r;
    endfunction

    task automatic send_beat(logic [1:0] cmd, t_key key, bit typed, t_result typed_res);
        t_result r;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_key_word_0 <= key[0*64 +: 64];
        i_key_word_1 <= key[1*64 +: 64];
        i_key_word_2 <= key[2*64 +: 64];
        i_key_word_3 <= key[3*64 +: 64];
        i_key_word_4 <= key[4*64 +: 64];
        i_key_word_5 <= key[5*64 +: 64];
        i_key_word_6 <= key[6*64 +: 64];
        i_key_word_7 <= key[7*64 +: 64];
        do @(posedge i_clk); while (busy);
        r = count_key(cmd, key);
        if (r.status == chkc_pkg::ST_FULL) full_seen++;
        if (r.status == chkc_pkg::ST_ABSENT) absent_seen++;
        pending_results.push_back(typed ? typed_res : r);
        beats_sent++;
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation pending");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_key_count !== e.key_count) begin
                    $error("key_count: expected %0d, got %0d", e.key_count, o_key_count);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    errors++;
                end
                if (o_distinct_keys !== e.distinct_keys) begin
                    $error("distinct_keys: expected %0d, got %0d",
                           e.distinct_keys, o_distinct_keys);
                    errors++;
                end
                if (o_total_hits !== e.total_hits) begin
                    $error("total_hits: expected %0d, got %0d", e.total_hits, o_total_hits);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout waiting for the key counter");
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_row   rows[$];
        t_key   dkeys[3];
        t_key   k;
        int     fill_id, kid, sel, w;
        logic [1:0] cmd;

        errors = 0;
        stored_keys = 0;
        hit_sum = '0;
        idle_pct = 25;
        full_seen = 0;
        absent_seen = 0;
        beats_sent = 0;

        dkeys[0] = '0;
        dkeys[1] = '1;
        dkeys[2] = '1;
        dkeys[2][7*64 +: 64] = '0;

        for (int i = 0; i < KEY_SET; i++) begin
            for (w = 0; w < 8; w++) begin
                k[w*64 +: 64] = ($urandom_range(7) == 0) ? 64'd0 : {$urandom, $urandom};
            end
            key_set[i] = k;
        end
        key_set[1] = key_set[0];
        key_set[1][3*64 +: 64] ^= 64'h1;
        key_set[2] = key_set[0];
        key_set[2][7*64 + 63] ^= 1'b1;

        rows = '{
            '{chkc_pkg::CMD_READ, 0, '{32'd0, chkc_pkg::ST_OK,     9'd0, 32'd0}},
            '{chkc_pkg::CMD_DEC,  0, '{32'd0, chkc_pkg::ST_ABSENT, 9'd0, 32'd0}},
            '{chkc_pkg::CMD_INC,  0, '{32'd1, chkc_pkg::ST_OK,     9'd1, 32'd1}},
            '{chkc_pkg::CMD_INC,  0, '{32'd2, chkc_pkg::ST_OK,     9'd1, 32'd2}},
            '{chkc_pkg::CMD_INC,  1, '{32'd1, chkc_pkg::ST_OK,     9'd2, 32'd3}},
            '{chkc_pkg::CMD_INC,  2, '{32'd1, chkc_pkg::ST_OK,     9'd3, 32'd4}},
            '{CMD_SPARE,          1, '{32'd1, chkc_pkg::ST_OK,     9'd3, 32'd4}},
            '{chkc_pkg::CMD_READ, 2, '{32'd1, chkc_pkg::ST_OK,     9'd3, 32'd4}},
            '{chkc_pkg::CMD_DEC,  1, '{32'd0, chkc_pkg::ST_OK,     9'd2, 32'd3}},
            '{chkc_pkg::CMD_READ, 1, '{32'd0, chkc_pkg::ST_OK,     9'd2, 32'd3}},
            '{chkc_pkg::CMD_DEC,  1, '{32'd0, chkc_pkg::ST_ABSENT, 9'd2, 32'd3}},
            '{chkc_pkg::CMD_DEC,  0, '{32'd1, chkc_pkg::ST_OK,     9'd2, 32'd2}},
            '{chkc_pkg::CMD_DEC,  0, '{32'd0, chkc_pkg::ST_OK,     9'd1, 32'd1}},
            '{chkc_pkg::CMD_DEC,  2, '{32'd0, chkc_pkg::ST_OK,     9'd0, 32'd0}}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_beat(rows[i].cmd, dkeys[rows[i].key_id], 1'b1, rows[i].res);
        end

        // Fill the pool with mostly fresh keys so the full status is reached.
        fill_id = 0;
        for (int i = 0; i < FILL_BEATS; i++) begin
            if ($urandom_range(99) < 90) begin
                cmd = chkc_pkg::CMD_INC;
                kid = fill_id;
                fill_id = (fill_id + 1) % KEY_SET;
            end else begin
                cmd = 2'($urandom_range(3));
                kid = $urandom_range(KEY_SET - 1);
            end
            send_beat(cmd, key_set[kid], 1'b0, '0);
        end

        for (int i = 0; i < MIX_BEATS; i++) begin
            idle_pct = (i >= 100 && i < 250) ? 0 : 25;
            if (i == 300) begin
                start <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            sel = $urandom_range(99);
            cmd = (sel < 35) ? chkc_pkg::CMD_INC :
                  (sel < 75) ? chkc_pkg::CMD_DEC :
                  (sel < 95) ? chkc_pkg::CMD_READ : CMD_SPARE;
            if ($urandom_range(9) == 0) begin
                for (w = 0; w < 8; w++) k[w*64 +: 64] = {$urandom, $urandom};
            end else begin
                k = key_set[$urandom_range(KEY_SET - 1)];
            end
            send_beat(cmd, k, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d command beats: %0d pool-full and %0d absent-key results,",
                 beats_sent, full_seen, absent_seen);
        $display("ending with %0d distinct keys stored.", stored_keys);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
